### hw/rtl/charlieplexed_led_scan_driver_core_assert.svh
// Assertion macros used by the checker file.
`ifndef CHARLIEPLEXED_LED_SCAN_DRIVER_CORE_ASSERT_SVH
`define CHARLIEPLEXED_LED_SCAN_DRIVER_CORE_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define CLS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define CLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cls_pkg.sv
package cls_pkg;

    // Display geometry
    localparam int NUM_ROWS = 5;
    localparam int NUM_COLS = 8;
    localparam int NUM_LEDS = 40;
    localparam int NUM_PINS = 7;

    localparam logic [6:0] PIN_MASK = 7'(((1 << NUM_PINS) - 1) & 8'h7F);

    // Operation codes
    localparam logic [2:0] OP_SET_PIXEL = 3'd0;
    localparam logic [2:0] OP_GET_PIXEL = 3'd1;
    localparam logic [2:0] OP_WRITE_ROW = 3'd2;
    localparam logic [2:0] OP_READ_ROW  = 3'd3;
    localparam logic [2:0] OP_LATCH     = 3'd4;
    localparam logic [2:0] OP_TICK      = 3'd5;

    typedef struct packed {
        logic [2:0] operation;
        logic [3:0] column;
        logic [2:0] row;
        logic       pixel_value;
        logic [7:0] row_data;
    } cls_cmd_t;

    typedef struct packed {
        logic       pixel_on;
        logic       out_of_range;
        logic [7:0] row_value;
        logic [6:0] pin_level;
        logic [6:0] pin_enable;
        logic [5:0] led_index;
    } cls_rsp_t;

    typedef struct packed {
        logic       pixel_on;
        logic       out_of_range;
        logic [7:0] row_value;
    } cls_frame_rsp_t;

    typedef struct packed {
        logic [6:0] pin_level;
        logic [6:0] pin_enable;
        logic [5:0] led_index;
    } cls_scan_rsp_t;

    // Pin level driven for each LED when lit
    function automatic logic [6:0] level_rom(input logic [5:0] idx);
        logic [7:0] v;
        case (idx)
            6'd0:  v = 8'h20;  6'd1:  v = 8'h01;  6'd2:  v = 8'h02;  6'd3:  v = 8'h04;
            6'd4:  v = 8'h10;  6'd5:  v = 8'h20;  6'd6:  v = 8'h40;  6'd7:  v = 8'h01;
            6'd8:  v = 8'h10;  6'd9:  v = 8'h40;  6'd10: v = 8'h01;  6'd11: v = 8'h02;
            6'd12: v = 8'h04;  6'd13: v = 8'h10;  6'd14: v = 8'h20;  6'd15: v = 8'h40;
            6'd16: v = 8'h08;  6'd17: v = 8'h10;  6'd18: v = 8'h40;  6'd19: v = 8'h01;
            6'd20: v = 8'h02;  6'd21: v = 8'h08;  6'd22: v = 8'h10;  6'd23: v = 8'h20;
            6'd24: v = 8'h04;  6'd25: v = 8'h08;  6'd26: v = 8'h20;  6'd27: v = 8'h40;
            6'd28: v = 8'h01;  6'd29: v = 8'h02;  6'd30: v = 8'h08;  6'd31: v = 8'h10;
            6'd32: v = 8'h02;  6'd33: v = 8'h04;  6'd34: v = 8'h08;  6'd35: v = 8'h20;
            6'd36: v = 8'h40;  6'd37: v = 8'h01;  6'd38: v = 8'h04;  6'd39: v = 8'h08;
            default: v = 8'h00;
        endcase
        return v[6:0] & PIN_MASK;
    endfunction

    // Output enable pattern for each LED
    function automatic logic [6:0] enable_rom(input logic [5:0] idx);
        logic [7:0] v;
        case (idx)
            6'd0:  v = 8'h60;  6'd1:  v = 8'h41;  6'd2:  v = 8'h22;  6'd3:  v = 8'h14;
            6'd4:  v = 8'h18;  6'd5:  v = 8'h24;  6'd6:  v = 8'h42;  6'd7:  v = 8'h03;
            6'd8:  v = 8'h50;  6'd9:  v = 8'h60;  6'd10: v = 8'h21;  6'd11: v = 8'h12;
            6'd12: v = 8'h0C;  6'd13: v = 8'h14;  6'd14: v = 8'h22;  6'd15: v = 8'h41;
            6'd16: v = 8'h48;  6'd17: v = 8'h30;  6'd18: v = 8'h50;  6'd19: v = 8'h11;
            6'd20: v = 8'h0A;  6'd21: v = 8'h0C;  6'd22: v = 8'h12;  6'd23: v = 8'h21;
            6'd24: v = 8'h44;  6'd25: v = 8'h28;  6'd26: v = 8'h30;  6'd27: v = 8'h48;
            6'd28: v = 8'h09;  6'd29: v = 8'h06;  6'd30: v = 8'h0A;  6'd31: v = 8'h11;
            6'd32: v = 8'h42;  6'd33: v = 8'h24;  6'd34: v = 8'h18;  6'd35: v = 8'h28;
            6'd36: v = 8'h44;  6'd37: v = 8'h05;  6'd38: v = 8'h06;  6'd39: v = 8'h09;
            default: v = 8'h00;
        endcase
        return v[6:0] & PIN_MASK;
    endfunction

endpackage

### hw/rtl/cls_cmd_if.sv
interface cls_cmd_if;
    logic               valid;
    logic               ready;
    cls_pkg::cls_cmd_t  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### hw/rtl/cls_rsp_if.sv
interface cls_rsp_if;
    logic               valid;
    logic               ready;
    cls_pkg::cls_rsp_t  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### hw/rtl/cls_frame.sv
module cls_frame (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  cls_pkg::cls_cmd_t               cmd,
    output cls_pkg::cls_frame_rsp_t         rsp,
    output logic [cls_pkg::NUM_LEDS-1:0]    lit
);
    import cls_pkg::*;

    logic [NUM_COLS-1:0] frame_reg  [NUM_ROWS];
    logic [NUM_COLS-1:0] frame_next [NUM_ROWS];
    logic [NUM_COLS-1:0] sel_row;
    logic                row_ok;
    logic                pix_ok;
    logic                pix_bit;

    assign row_ok = (4'(cmd.row) < 4'(NUM_ROWS));
    assign pix_ok = row_ok && (5'(cmd.column) < 5'(NUM_COLS));

    // Select the addressed row and pixel
    always_comb
    begin
        sel_row = '0;
        pix_bit = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (cmd.row == 3'(r))
            begin
                sel_row = frame_reg[r];
            end
        end
        for (int c = 0; c < NUM_COLS; c++)
        begin
            if (cmd.column == 4'(c))
            begin
                pix_bit = sel_row[c];
            end
        end
    end

    // Form the frame part of the result
    always_comb
    begin
        rsp = '0;
        case (cmd.operation)
            OP_SET_PIXEL:
            begin
                rsp.out_of_range = !pix_ok;
            end
            OP_GET_PIXEL:
            begin
                rsp.out_of_range = !pix_ok;
                rsp.pixel_on     = pix_ok && pix_bit;
            end
            OP_WRITE_ROW:
            begin
                rsp.out_of_range = !row_ok;
            end
            OP_READ_ROW:
            begin
                rsp.out_of_range = !row_ok;
                for (int c = 0; c < NUM_COLS; c++)
                begin
                    rsp.row_value[c] = row_ok && sel_row[c];
                end
            end
            default:
            begin
                rsp = '0;
            end
        endcase
    end

    // Update pixels and rows
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            frame_next[r] = frame_reg[r];
            for (int c = 0; c < NUM_COLS; c++)
            begin
                if (accept && cmd.operation == OP_SET_PIXEL && pix_ok
                    && cmd.row == 3'(r) && cmd.column == 4'(c))
                begin
                    frame_next[r][c] = cmd.pixel_value;
                end
                if (accept && cmd.operation == OP_WRITE_ROW && row_ok
                    && cmd.row == 3'(r))
                begin
                    frame_next[r][c] = cmd.row_data[c];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                frame_reg[r] <= '0;
            end
        end
        else
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                frame_reg[r] <= frame_next[r];
            end
        end
    end

    // Map LED i onto row i / NUM_COLS, column i % NUM_COLS
    for (genvar i = 0; i < NUM_LEDS; i++)
    begin : g_lit
        if ((i / NUM_COLS) < NUM_ROWS)
        begin : g_in
            assign lit[i] = frame_reg[i / NUM_COLS][i % NUM_COLS];
        end
        else
        begin : g_out
            assign lit[i] = 1'b0;
        end
    end

endmodule

### hw/rtl/cls_scan.sv
module cls_scan (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [2:0]                      operation,
    input  logic [cls_pkg::NUM_LEDS-1:0]    lit,
    output cls_pkg::cls_scan_rsp_t          rsp
);
    import cls_pkg::*;

    logic [NUM_LEDS-1:0] snap_reg;
    logic                latched_reg;
    logic [5:0]          pos_reg;
    logic [5:0]          pos_next;
    logic [5:0]          idx;
    logic                idx_lit;

    // Restart the scan when the position has run past the last LED
    assign idx = (7'(pos_reg) >= 7'(NUM_LEDS)) ? 6'd0 : pos_reg;

    always_comb
    begin
        idx_lit = 1'b0;
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            if (idx == 6'(i))
            begin
                idx_lit = snap_reg[i];
            end
        end
    end

    assign pos_next = 6'(idx + 6'd1);

    // Drive the tick result, zero for every other operation
    always_comb
    begin
        rsp = '0;
        if (operation == OP_TICK)
        begin
            rsp.led_index  = idx;
            rsp.pin_level  = idx_lit ? level_rom(idx) : 7'd0;
            rsp.pin_enable = latched_reg ? enable_rom(idx) : 7'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_reg    <= '0;
            latched_reg <= 1'b0;
            pos_reg     <= '0;
        end
        else if (accept)
        begin
            if (operation == OP_LATCH)
            begin
                snap_reg    <= lit;
                latched_reg <= 1'b1;
            end
            if (operation == OP_TICK)
            begin
                pos_reg <= pos_next;
            end
        end
    end

endmodule

### hw/rtl/charlieplexed_led_scan_driver_core.sv
// Charlieplexed 5x8 LED scan driver on seven tri-state pins.
// cmd carries one operation per transaction: set or get a pixel, write or
// read a row, latch the frame into the drive snapshot, or tick the scan.
// rsp returns exactly one transaction per command, in order; fields that do
// not belong to the operation read zero.
// The response is registered and is valid in the cycle after the command is taken.
// Throughput: one command per cycle while the response side is ready; the frame store,
// snapshot and the two pin ROMs are all reached combinationally behind the response register.
// cmd.ready is high whenever the response register is empty or is being
// drained in the same cycle, so a stalled receiver holds the response and
// back-pressures cmd after one command.
// Reset clears the frame, the snapshot, the latched flag and the scan
// position; the first tick after reset scans LED 0 with all pins disabled.
module charlieplexed_led_scan_driver_core (
    input  logic        clk,
    input  logic        rst_n,
    cls_cmd_if.sink     cmd,
    cls_rsp_if.source   rsp
);
    import cls_pkg::*;

    logic           accept;
    logic           rsp_valid_reg;
    logic           rsp_valid_next;
    cls_rsp_t       rsp_reg;
    cls_rsp_t       rsp_next;
    cls_frame_rsp_t frame_rsp;
    cls_scan_rsp_t  scan_rsp;
    logic [NUM_LEDS-1:0] lit;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    cls_frame u_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd.item),
        .rsp    (frame_rsp),
        .lit    (lit)
    );

    cls_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (cmd.item.operation),
        .lit       (lit),
        .rsp       (scan_rsp)
    );

    // Merge the two halves of the result
    always_comb
    begin
        rsp_next.pixel_on     = frame_rsp.pixel_on;
        rsp_next.out_of_range = frame_rsp.out_of_range;
        rsp_next.row_value    = frame_rsp.row_value;
        rsp_next.pin_level    = scan_rsp.pin_level;
        rsp_next.pin_enable   = scan_rsp.pin_enable;
        rsp_next.led_index    = scan_rsp.led_index;
    end

    // Hold the response until taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.item  = rsp_reg;

endmodule

### hw/rtl/cls_checker.sv
`include "charlieplexed_led_scan_driver_core_assert.svh"

module cls_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic        cmd_ready,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic        pixel_on,
    input  logic        out_of_range,
    input  logic [7:0]  row_value,
    input  logic [6:0]  pin_level,
    input  logic [6:0]  pin_enable,
    input  logic [5:0]  led_index
);

    // A stalled response stays up
    `CLS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

    // Every taken command shows a response in the next cycle
    `CLS_ASSERT_NEXT(a_rsp_follows, clk, rst_n, cmd_valid && cmd_ready, rsp_valid, "command taken without response")

    // A driven pin is always enabled
    `CLS_ASSERT_IMPLIES(a_level_enabled, clk, rst_n, rsp_valid, (pin_level & ~pin_enable) == 7'd0, "pin driven while disabled")

    // Scan fields never mix with frame fields
    `CLS_ASSERT_IMPLIES(a_fields_apart, clk, rst_n, rsp_valid && (pin_level != 7'd0 || pin_enable != 7'd0 || led_index != 6'd0), !pixel_on && !out_of_range && row_value == 8'd0, "scan and frame fields both set")

endmodule

bind charlieplexed_led_scan_driver_core cls_checker u_cls_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .pixel_on     (rsp.item.pixel_on),
    .out_of_range (rsp.item.out_of_range),
    .row_value    (rsp.item.row_value),
    .pin_level    (rsp.item.pin_level),
    .pin_enable   (rsp.item.pin_enable),
    .led_index    (rsp.item.led_index)
);

### test/tb_charlieplexed_led_scan_driver_core.sv
module tb_charlieplexed_led_scan_driver_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cls_pkg::*;

    // Spare operation codes, which the block answers with an all-zero response
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_CYCLES    = 120;
    localparam int PRINT_LIMIT    = 200;
    localparam int PHASE_ITEMS    = 270;
    localparam int PRESSURE_ITEMS = 40;

    // Pin level for each LED when it is lit
    localparam logic [7:0] LED_LEVEL [0:NUM_LEDS-1] = '{
        8'h20, 8'h01, 8'h02, 8'h04, 8'h10, 8'h20, 8'h40, 8'h01,
        8'h10, 8'h40, 8'h01, 8'h02, 8'h04, 8'h10, 8'h20, 8'h40,
        8'h08, 8'h10, 8'h40, 8'h01, 8'h02, 8'h08, 8'h10, 8'h20,
        8'h04, 8'h08, 8'h20, 8'h40, 8'h01, 8'h02, 8'h08, 8'h10,
        8'h02, 8'h04, 8'h08, 8'h20, 8'h40, 8'h01, 8'h04, 8'h08
    };

    // Pin output enables for each LED
    localparam logic [7:0] LED_ENABLE [0:NUM_LEDS-1] = '{
        8'h60, 8'h41, 8'h22, 8'h14, 8'h18, 8'h24, 8'h42, 8'h03,
        8'h50, 8'h60, 8'h21, 8'h12, 8'h0C, 8'h14, 8'h22, 8'h41,
        8'h48, 8'h30, 8'h50, 8'h11, 8'h0A, 8'h0C, 8'h12, 8'h21,
        8'h44, 8'h28, 8'h30, 8'h48, 8'h09, 8'h06, 8'h0A, 8'h11,
        8'h42, 8'h24, 8'h18, 8'h28, 8'h44, 8'h05, 8'h06, 8'h09
    };

    logic clk = 1'b0;
    logic rst_n;

    cls_cmd_if cmd_ch ();
    cls_rsp_if rsp_ch ();

    charlieplexed_led_scan_driver_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Shadow of the display state
    logic [NUM_COLS-1:0] shadow_frame [0:NUM_ROWS-1];
    logic [NUM_LEDS-1:0] shadow_snapshot;
    logic                shadow_latched;
    logic [5:0]          shadow_scan_pos;

    cls_cmd_t cmd_backlog [$];
    cls_rsp_t expected_rsp_q [$];

    int  issued_cmds     = 0;
    int  accepted_cmds   = 0;
    int  error_count     = 0;
    int  cycle_count     = 0;
    int  source_idle_pct = 0;
    int  sink_stall_pct  = 0;
    int  holds_requested = 0;
    int  holds_served    = 0;
    int  hold_left       = 0;
    bit  cmd_taken       = 1'b0;

    // Free-running clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Work out the response to one command and advance the shadow state
    function automatic cls_rsp_t predict_scan_response(input cls_cmd_t c);
        cls_rsp_t r;
        logic     row_ok;
        logic     pix_ok;
        r = '0;
        row_ok = c.row < NUM_ROWS;
        pix_ok = row_ok && (c.column < NUM_COLS);
        case (c.operation)
            OP_SET_PIXEL:
                if (pix_ok)
                    shadow_frame[c.row][c.column[2:0]] = c.pixel_value;
                else
                    r.out_of_range = 1'b1;
            OP_GET_PIXEL:
                if (pix_ok)
                    r.pixel_on = shadow_frame[c.row][c.column[2:0]];
                else
                    r.out_of_range = 1'b1;
            OP_WRITE_ROW:
                if (row_ok)
                    shadow_frame[c.row] = c.row_data[NUM_COLS-1:0];
                else
                    r.out_of_range = 1'b1;
            OP_READ_ROW:
                if (row_ok)
                    r.row_value = 8'(shadow_frame[c.row]);
                else
                    r.out_of_range = 1'b1;
            OP_LATCH:
            begin
                for (int i = 0; i < NUM_LEDS; i++)
                    shadow_snapshot[i] = shadow_frame[i / NUM_COLS][i % NUM_COLS];
                shadow_latched = 1'b1;
            end
            OP_TICK:
            begin
                if (shadow_scan_pos >= NUM_LEDS)
                    shadow_scan_pos = '0;
                r.led_index = shadow_scan_pos;
                if (shadow_snapshot[shadow_scan_pos])
                    r.pin_level = LED_LEVEL[shadow_scan_pos][6:0] & PIN_MASK;
                if (shadow_latched)
                    r.pin_enable = LED_ENABLE[shadow_scan_pos][6:0] & PIN_MASK;
                shadow_scan_pos = shadow_scan_pos + 6'd1;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // Random command: mostly legal operations on pixels and rows in the frame
    function automatic cls_cmd_t random_cmd();
        cls_cmd_t    c;
        int unsigned pick;
        c.operation   = 3'($urandom_range(0, 7));
        c.column      = 4'($urandom_range(0, 15));
        c.row         = 3'($urandom_range(0, 7));
        c.pixel_value = 1'($urandom_range(0, 1));
        c.row_data    = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 90)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 14)
                c.operation = OP_SET_PIXEL;
            else if (pick < 26)
                c.operation = OP_GET_PIXEL;
            else if (pick < 35)
                c.operation = OP_WRITE_ROW;
            else if (pick < 45)
                c.operation = OP_READ_ROW;
            else if (pick < 53)
                c.operation = OP_LATCH;
            else if (pick < 97)
                c.operation = OP_TICK;
            else if (pick < 99)
                c.operation = OP_SPARE_LO;
            else
                c.operation = OP_SPARE_HI;
            if ($urandom_range(0, 9) != 0)
            begin
                c.column = 4'($urandom_range(0, NUM_COLS - 1));
                c.row    = 3'($urandom_range(0, NUM_ROWS - 1));
            end
        end
        return c;
    endfunction

    task automatic push_cmd(input cls_cmd_t c);
        cmd_backlog.push_back(c);
        issued_cmds++;
    endtask

    // Hold until every command is taken and every response has come back
    task automatic drain_all();
        while (accepted_cmds != issued_cmds || expected_rsp_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string label, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            error_count++;
            if (error_count <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, label, want, got);
        end
    endtask

    // Command driver: offer the next pending transaction once the last is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_ch.valid <= 1'b0;
        else if (!cmd_ch.valid || cmd_taken)
        begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= source_idle_pct)
            begin
                cmd_ch.item  <= cmd_backlog.pop_front();
                cmd_ch.valid <= 1'b1;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // Response ready: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (holds_served != holds_requested)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Monitor: check each response, then predict for each command taken
    always @(posedge clk)
    begin : monitor
        cls_rsp_t want;
        cmd_taken = rst_n && cmd_ch.valid && cmd_ch.ready;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                error_count++;
                if (error_count <= PRINT_LIMIT)
                    $display("%0t: response with none expected, actual 0x%0h",
                             $time, rsp_ch.item);
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                check_field("pixel_on", 8'(want.pixel_on), 8'(rsp_ch.item.pixel_on));
                check_field("out_of_range", 8'(want.out_of_range),
                            8'(rsp_ch.item.out_of_range));
                check_field("row_value", want.row_value, rsp_ch.item.row_value);
                check_field("pin_level", 8'(want.pin_level), 8'(rsp_ch.item.pin_level));
                check_field("pin_enable", 8'(want.pin_enable),
                            8'(rsp_ch.item.pin_enable));
                check_field("led_index", 8'(want.led_index), 8'(rsp_ch.item.led_index));
            end
        end
        if (cmd_taken)
        begin
            expected_rsp_q.push_back(predict_scan_response(cmd_ch.item));
            accepted_cmds++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus and phase control
    initial
    begin
        int src_pct [4];
        int snk_pct [4];
        src_pct = '{0, 85, 0, 8};
        snk_pct = '{0, 0, 85, 8};

        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.item  = '0;
        rsp_ch.ready = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++)
            shadow_frame[r] = '0;
        shadow_snapshot = '0;
        shadow_latched  = 1'b0;
        shadow_scan_pos = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: tick before any latch, pixel and row edges, latch, spare codes
        push_cmd(cls_cmd_t'{OP_TICK,      4'd0,  3'd0, 1'b0, 8'h00});
        push_cmd(cls_cmd_t'{OP_SET_PIXEL, 4'd0,  3'd0, 1'b1, 8'h00});
        push_cmd(cls_cmd_t'{OP_SET_PIXEL, 4'd7,  3'd4, 1'b1, 8'h00});
        push_cmd(cls_cmd_t'{OP_SET_PIXEL, 4'd15, 3'd7, 1'b1, 8'hFF});
        push_cmd(cls_cmd_t'{OP_SET_PIXEL, 4'd8,  3'd0, 1'b1, 8'h00});
        push_cmd(cls_cmd_t'{OP_SET_PIXEL, 4'd0,  3'd5, 1'b1, 8'h00});
        push_cmd(cls_cmd_t'{OP_GET_PIXEL, 4'd0,  3'd0, 1'b0, 8'h00});
        push_cmd(cls_cmd_t'{OP_GET_PIXEL, 4'd7,  3'd4, 1'b0, 8'h00});
        push_cmd(cls_cmd_t'{OP_GET_PIXEL, 4'd15, 3'd7, 1'b1, 8'h00});
        push_cmd(cls_cmd_t'{OP_WRITE_ROW, 4'd0,  3'd0, 1'b0, 8'hFF});
        push_cmd(cls_cmd_t'{OP_WRITE_ROW, 4'd15, 3'd4, 1'b1, 8'hA5});
        push_cmd(cls_cmd_t'{OP_WRITE_ROW, 4'd0,  3'd7, 1'b0, 8'h3C});
        push_cmd(cls_cmd_t'{OP_READ_ROW,  4'd0,  3'd0, 1'b0, 8'h00});
        push_cmd(cls_cmd_t'{OP_READ_ROW,  4'd0,  3'd4, 1'b0, 8'h00});
        push_cmd(cls_cmd_t'{OP_READ_ROW,  4'd0,  3'd5, 1'b0, 8'h00});
        push_cmd(cls_cmd_t'{OP_SET_PIXEL, 4'd3,  3'd0, 1'b0, 8'h00});
        push_cmd(cls_cmd_t'{OP_READ_ROW,  4'd0,  3'd0, 1'b0, 8'h00});
        push_cmd(cls_cmd_t'{OP_LATCH,     4'd0,  3'd0, 1'b0, 8'h00});
        repeat (4)
            push_cmd(cls_cmd_t'{OP_TICK, 4'd0, 3'd0, 1'b0, 8'h00});
        push_cmd(cls_cmd_t'{OP_SPARE_LO,  4'd15, 3'd7, 1'b1, 8'hFF});
        push_cmd(cls_cmd_t'{OP_SPARE_HI,  4'd15, 3'd7, 1'b1, 8'hFF});
        push_cmd(cls_cmd_t'{OP_TICK,      4'd15, 3'd7, 1'b1, 8'hFF});
        drain_all();

        // Random phases with different idling on each side
        for (int p = 0; p < 4; p++)
        begin
            source_idle_pct = src_pct[p];
            sink_stall_pct  = snk_pct[p];
            repeat (PHASE_ITEMS)
                push_cmd(random_cmd());
            drain_all();

            // Back-pressure: hold the response side while commands keep coming
            if (p == 0)
            begin
                holds_requested++;
                repeat (PRESSURE_ITEMS)
                    push_cmd(random_cmd());
                drain_all();
            end
        end

        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
